>>> rtl/stt_pkg.sv
// Shared types, token codes and character tables for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int NUM_OPS     = 36;
    localparam int NUM_KW      = 49;
    localparam int KW_TEXT_LEN = 20;
    localparam int MAX_RESULTS = 6;

    localparam logic [5:0] K_IDENT  = 6'd55;
    localparam logic [5:0] K_NUMBER = 6'd56;
    localparam logic [5:0] K_HEX    = 6'd57;
    localparam logic [5:0] K_BINARY = 6'd58;
    localparam logic [5:0] K_FLOAT  = 6'd59;
    localparam logic [5:0] K_STRING = 6'd60;
    localparam logic [5:0] K_CHAR   = 6'd61;
    localparam logic [5:0] K_EOF    = 6'd62;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_BYTE   = 2'd1;
    localparam logic [1:0] ERR_STRING = 2'd2;
    localparam logic [1:0] ERR_CHAR   = 2'd3;

    localparam logic [NUM_KW-1:0] ALL_KW = {NUM_KW{1'b1}};

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] line;
        logic [15:0] column;
        logic [23:0] offset;
        logic [15:0] length;
        logic [1:0]  err;
    } rec_t;

    typedef struct packed {
        rec_t [MAX_RESULTS-1:0] recs;
        logic [2:0]             cnt;
    } bundle_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    // Single-character operators: valid bit above the kind.
    function automatic logic [6:0] op1(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        case (c)
            "+": r = {1'b1, 6'd14};
            "-": r = {1'b1, 6'd15};
            "*": r = {1'b1, 6'd16};
            "/": r = {1'b1, 6'd17};
            "=": r = {1'b1, 6'd18};
            "<": r = {1'b1, 6'd19};
            ">": r = {1'b1, 6'd20};
            "!": r = {1'b1, 6'd21};
            "^": r = {1'b1, 6'd24};
            "~": r = {1'b1, 6'd25};
            "{": r = {1'b1, 6'd26};
            "}": r = {1'b1, 6'd27};
            "(": r = {1'b1, 6'd28};
            ")": r = {1'b1, 6'd29};
            ";": r = {1'b1, 6'd30};
            ",": r = {1'b1, 6'd31};
            "%": r = {1'b1, 6'd32};
            ":": r = {1'b1, 6'd33};
            "[": r = {1'b1, 6'd34};
            "]": r = {1'b1, 6'd35};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] op2(input logic [7:0] c0, input logic [7:0] c1);
        logic [6:0] r;
        r = 7'd0;
        case ({c0, c1})
            "==": r = {1'b1, 6'd0};
            "!=": r = {1'b1, 6'd1};
            "<=": r = {1'b1, 6'd2};
            ">=": r = {1'b1, 6'd3};
            "<<": r = {1'b1, 6'd4};
            ">>": r = {1'b1, 6'd5};
            "->": r = {1'b1, 6'd6};
            "+=": r = {1'b1, 6'd7};
            "-=": r = {1'b1, 6'd8};
            "*=": r = {1'b1, 6'd9};
            "/=": r = {1'b1, 6'd10};
            "%=": r = {1'b1, 6'd11};
            "++": r = {1'b1, 6'd12};
            "--": r = {1'b1, 6'd13};
            "&&": r = {1'b1, 6'd22};
            "||": r = {1'b1, 6'd23};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic has_two(input logic [7:0] c);
        return c == "=" || c == "!" || c == "<" || c == ">" || c == "-" || c == "+" ||
               c == "*" || c == "/" || c == "%" || c == "&" || c == "|";
    endfunction

    function automatic logic [8*KW_TEXT_LEN-1:0] kw_text(input logic [5:0] k);
        logic [8*KW_TEXT_LEN-1:0] t;
        t = '0;
        case (k)
            6'd0:  t = "plus";
            6'd1:  t = "minus";
            6'd2:  t = "multiply";
            6'd3:  t = "divide";
            6'd4:  t = "equals";
            6'd5:  t = "equalsEquals";
            6'd6:  t = "notEquals";
            6'd7:  t = "lessThan";
            6'd8:  t = "lessThanOrEquals";
            6'd9:  t = "greaterThan";
            6'd10: t = "greaterThanOrEquals";
            6'd11: t = "and";
            6'd12: t = "or";
            6'd13: t = "xor";
            6'd14: t = "complement";
            6'd15: t = "leftShift";
            6'd16: t = "rightShift";
            6'd17: t = "pointer";
            6'd18: t = "plusEquals";
            6'd19: t = "minusEquals";
            6'd20: t = "multiplyEquals";
            6'd21: t = "divideEquals";
            6'd22: t = "modEquals";
            6'd23: t = "doing";
            6'd24: t = "finish";
            6'd25: t = "open";
            6'd26: t = "close";
            6'd27: t = "to";
            6'd28: t = "end";
            6'd29: t = "make";
            6'd30: t = "list";
            6'd31: t = "const";
            6'd32: t = "true";
            6'd33: t = "false";
            6'd34: t = "function";
            6'd35: t = "beginParams";
            6'd36: t = "endParams";
            6'd37: t = "if";
            6'd38: t = "else";
            6'd39: t = "while";
            6'd40: t = "for";
            6'd41: t = "return";
            6'd42: t = "none";
            6'd43: t = "NULL";
            6'd44: t = "stop";
            6'd45: t = "continue";
            6'd46: t = "switch";
            6'd47: t = "when";
            6'd48: t = "default";
            default: t = '0;
        endcase
        return t;
    endfunction

    // Character i of keyword k, zero past its end.
    function automatic logic [7:0] kw_char(input logic [5:0] k, input logic [4:0] i);
        logic [8*KW_TEXT_LEN-1:0] t;
        int                       n;
        logic [7:0]               r;
        t = kw_text(k);
        n = 0;
        for (int j = 0; j < KW_TEXT_LEN; j++) begin
            if (t[8*j +: 8] != 8'h00) begin
                n = j + 1;
            end
        end
        r = 8'h00;
        if (int'(i) < n) begin
            r = t[8*(n-1-int'(i)) +: 8];
        end
        return r;
    endfunction

    function automatic logic [5:0] kw_kind_of(input logic [5:0] k);
        logic [5:0] r;
        r = K_IDENT;
        case (k)
            6'd0: r = 6'd14;   6'd1: r = 6'd15;   6'd2: r = 6'd16;   6'd3: r = 6'd17;
            6'd4: r = 6'd18;   6'd5: r = 6'd0;    6'd6: r = 6'd1;    6'd7: r = 6'd19;
            6'd8: r = 6'd2;    6'd9: r = 6'd20;   6'd10: r = 6'd3;   6'd11: r = 6'd22;
            6'd12: r = 6'd23;  6'd13: r = 6'd24;  6'd14: r = 6'd25;  6'd15: r = 6'd4;
            6'd16: r = 6'd5;   6'd17: r = 6'd6;   6'd18: r = 6'd7;   6'd19: r = 6'd8;
            6'd20: r = 6'd9;   6'd21: r = 6'd10;  6'd22: r = 6'd11;  6'd23: r = 6'd26;
            6'd24: r = 6'd27;  6'd25: r = 6'd28;  6'd26: r = 6'd29;  6'd27: r = 6'd36;
            6'd28: r = 6'd30;  6'd29: r = 6'd37;  6'd30: r = 6'd38;  6'd31: r = 6'd39;
            6'd32: r = 6'd40;  6'd33: r = 6'd41;  6'd34: r = 6'd42;  6'd35: r = 6'd28;
            6'd36: r = 6'd29;  6'd37: r = 6'd43;  6'd38: r = 6'd44;  6'd39: r = 6'd45;
            6'd40: r = 6'd46;  6'd41: r = 6'd47;  6'd42: r = 6'd48;  6'd43: r = 6'd49;
            6'd44: r = 6'd50;  6'd45: r = 6'd51;  6'd46: r = 6'd52;  6'd47: r = 6'd53;
            6'd48: r = 6'd54;
            default: r = K_IDENT;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

>>> rtl/stt_front.sv
// Front end: classifies each source byte and builds the token words it completes.
`timescale 1ns / 1ps

module stt_front
    import stt_pkg::*;
#(
    parameter int MAX_KEYWORD_LEN = 19,
    parameter int POSITION_BITS   = 24
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    char_code,
    input  logic          end_of_source,
    output logic          push,
    output bundle_t       push_data
);

    typedef enum logic [3:0] {
        M_IDLE, M_OPQ, M_COMMENT, M_IDENT, M_ZERO, M_DEC, M_DECDOT,
        M_HEX, M_BIN, M_FRAC, M_EXPE, M_EXPD, M_STRING, M_CHAR
    } mode_t;

    typedef struct packed {
        logic [19:0]              line;
        logic [15:0]              column;
        logic [POSITION_BITS-1:0] offset;
    } spot_t;

    typedef struct packed {
        rec_t       r0;
        rec_t       r1;
        logic [1:0] cnt;
    } end_t;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    mode_t                    mode_reg, mode_next;
    logic [7:0]               la_reg, la_next;
    logic [NUM_KW-1:0]        cand_reg, cand_next;
    logic [15:0]              len_reg, len_next;
    logic [19:0]              line_reg, line_next;
    logic [15:0]              col_reg, col_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    spot_t                    start_reg, start_next;
    spot_t                    pend_reg, pend_next;

    rec_t [MAX_RESULTS-1:0]   recs;
    logic [2:0]               nrec;
    spot_t                    here;
    spot_t                    eof_spot;
    end_t                     e1;
    end_t                     e2;
    logic                     do_end;
    logic                     do_idle;
    logic [6:0]               o1;
    logic [6:0]               o2;

    function automatic logic [23:0] to24(input logic [POSITION_BITS-1:0] x);
        logic [POSITION_BITS+23:0] w;
        w = {24'd0, x};
        return w[23:0];
    endfunction

    function automatic rec_t mkrec(input logic [5:0] kind, input spot_t s,
                                   input logic [POSITION_BITS-1:0] off,
                                   input logic [15:0] len, input logic [1:0] err);
        rec_t r;
        r.kind   = kind;
        r.line   = s.line;
        r.column = s.column;
        r.offset = to24(off);
        r.length = len;
        r.err    = err;
        return r;
    endfunction

    function automatic logic [NUM_KW-1:0] kw_upd(input logic [NUM_KW-1:0] cand,
                                                 input logic [7:0] c, input logic [15:0] i);
        logic [NUM_KW-1:0] r;
        logic [7:0]        ch;
        r = cand;
        if (int'(i) >= MAX_KEYWORD_LEN) begin
            r = '0;
        end
        else begin
            for (int k = 0; k < NUM_KW; k++) begin
                ch = (i < 16'(KW_TEXT_LEN)) ? kw_char(6'(k), i[4:0]) : 8'h00;
                if (ch != c) begin
                    r[k] = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] kw_kind(input logic [NUM_KW-1:0] cand,
                                           input logic [15:0] n);
        logic [5:0] r;
        logic [7:0] ch;
        r = K_IDENT;
        if (int'(n) <= MAX_KEYWORD_LEN) begin
            for (int k = NUM_KW - 1; k >= 0; k--) begin
                ch = (n < 16'(KW_TEXT_LEN)) ? kw_char(6'(k), n[4:0]) : 8'h00;
                if (cand[k] && ch == 8'h00) begin
                    r = kw_kind_of(6'(k));
                end
            end
        end
        return r;
    endfunction

    // Flush of the open token with no further bytes.
    function automatic end_t end_recs(input mode_t m, input spot_t s, input spot_t pd,
                                      input logic [7:0] la, input logic [15:0] n,
                                      input logic [NUM_KW-1:0] cand);
        end_t       e;
        logic [6:0] o;
        e     = '0;
        o     = op1(la);
        unique case (m)
            M_OPQ: begin
                e.cnt = 2'd1;
                e.r0  = o[6] ? mkrec(o[5:0], s, s.offset, 16'd1, ERR_NONE)
                             : mkrec(K_EOF, s, s.offset, 16'd1, ERR_BYTE);
            end
            M_IDENT: begin
                e.cnt = 2'd1;
                e.r0  = mkrec(kw_kind(cand, n), s, s.offset, n, ERR_NONE);
            end
            M_ZERO, M_DEC: begin
                e.cnt = 2'd1;
                e.r0  = mkrec(K_NUMBER, s, s.offset, n, ERR_NONE);
            end
            M_DECDOT: begin
                e.cnt = 2'd2;
                e.r0  = mkrec(K_NUMBER, s, s.offset, n, ERR_NONE);
                e.r1  = mkrec(K_EOF, pd, pd.offset, 16'd1, ERR_BYTE);
            end
            M_HEX: begin
                e.cnt = 2'd1;
                e.r0  = mkrec(K_HEX, s, s.offset, n, ERR_NONE);
            end
            M_BIN: begin
                e.cnt = 2'd1;
                e.r0  = mkrec(K_BINARY, s, s.offset, n, ERR_NONE);
            end
            M_FRAC, M_EXPE, M_EXPD: begin
                e.cnt = 2'd1;
                e.r0  = mkrec(K_FLOAT, s, s.offset, n, ERR_NONE);
            end
            M_STRING: begin
                e.cnt = 2'd1;
                e.r0  = mkrec(K_STRING, s, s.offset + POS_ONE, n, ERR_STRING);
            end
            M_CHAR: begin
                e.cnt = 2'd1;
                e.r0  = mkrec(K_CHAR, s, s.offset + POS_ONE, 16'd0, ERR_CHAR);
            end
            default: e.cnt = 2'd0;
        endcase
        return e;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        la_next    = la_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        pend_next  = pend_reg;
        recs       = '0;
        nrec       = 3'd0;
        do_end     = 1'b0;
        do_idle    = 1'b0;
        here       = '{line: line_reg, column: col_reg, offset: pos_reg};
        o2         = op2(la_reg, char_code);

        // A leading zero not followed by a radix letter is an ordinary decimal.
        if (mode_next == M_ZERO && !(char_code == "x" || char_code == "X" ||
                                     char_code == "b" || char_code == "B")) begin
            mode_next = M_DEC;
        end

        unique case (mode_next)
            M_IDLE: do_idle = 1'b1;
            M_COMMENT: begin
                if (char_code == 8'h0A) begin
                    mode_next = M_IDLE;
                end
            end
            M_OPQ: begin
                if (la_reg == "/" && char_code == "/") begin
                    mode_next = M_COMMENT;
                    len_next  = 16'd0;
                    cand_next = ALL_KW;
                end
                else if (o2[6]) begin
                    recs[nrec] = mkrec(o2[5:0], start_reg, start_reg.offset, 16'd2, ERR_NONE);
                    nrec       = nrec + 3'd1;
                    mode_next  = M_IDLE;
                    len_next   = 16'd0;
                    cand_next  = ALL_KW;
                end
                else begin
                    do_end  = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alpha(char_code) || is_digit(char_code) || char_code == "_") begin
                    cand_next = kw_upd(cand_reg, char_code, len_reg);
                    len_next  = sat_inc16(len_reg);
                end
                else begin
                    do_end = 1'b1;
                end
            end
            M_ZERO: begin
                mode_next = (char_code == "x" || char_code == "X") ? M_HEX : M_BIN;
                len_next  = sat_inc16(len_reg);
            end
            M_DEC: begin
                if (is_digit(char_code)) begin
                    len_next = sat_inc16(len_reg);
                end
                else if (char_code == ".") begin
                    mode_next = M_DECDOT;
                    la_next   = char_code;
                    pend_next = here;
                end
                else begin
                    do_end = 1'b1;
                end
            end
            M_DECDOT: begin
                if (is_digit(char_code)) begin
                    mode_next = M_FRAC;
                    len_next  = sat_inc16(sat_inc16(len_reg));
                end
                else begin
                    do_end = 1'b1;
                end
            end
            M_HEX: begin
                if (is_hexd(char_code)) len_next = sat_inc16(len_reg);
                else do_end = 1'b1;
            end
            M_BIN: begin
                if (char_code == "0" || char_code == "1") len_next = sat_inc16(len_reg);
                else do_end = 1'b1;
            end
            M_FRAC: begin
                if (is_digit(char_code)) begin
                    len_next = sat_inc16(len_reg);
                end
                else if (char_code == "e" || char_code == "E") begin
                    mode_next = M_EXPE;
                    len_next  = sat_inc16(len_reg);
                end
                else begin
                    do_end = 1'b1;
                end
            end
            M_EXPE: begin
                if (char_code == "+" || char_code == "-" || is_digit(char_code)) begin
                    mode_next = M_EXPD;
                    len_next  = sat_inc16(len_reg);
                end
                else begin
                    do_end = 1'b1;
                end
            end
            M_EXPD: begin
                if (is_digit(char_code)) len_next = sat_inc16(len_reg);
                else do_end = 1'b1;
            end
            M_STRING: begin
                if (char_code == 8'h22) begin
                    recs[nrec] = mkrec(K_STRING, start_reg, start_reg.offset + POS_ONE,
                                       len_reg, ERR_NONE);
                    nrec       = nrec + 3'd1;
                    mode_next  = M_IDLE;
                    len_next   = 16'd0;
                    cand_next  = ALL_KW;
                end
                else begin
                    len_next = sat_inc16(len_reg);
                end
            end
            M_CHAR: begin
                if (char_code == 8'h27 || char_code == 8'h0A) begin
                    recs[nrec] = mkrec(K_CHAR, start_reg, start_reg.offset + POS_ONE, len_reg,
                                       (char_code == 8'h0A) ? ERR_CHAR : ERR_NONE);
                    nrec       = nrec + 3'd1;
                    mode_next  = M_IDLE;
                    len_next   = 16'd0;
                    cand_next  = ALL_KW;
                end
                else begin
                    len_next = sat_inc16(len_reg);
                end
            end
            default: begin
                mode_next = M_IDLE;
                len_next  = 16'd0;
                cand_next = ALL_KW;
                do_idle   = 1'b1;
            end
        endcase

        e1 = end_recs(mode_next, start_reg, pend_reg, la_reg, len_reg, cand_reg);
        if (do_end) begin
            if (e1.cnt != 2'd0) begin
                recs[nrec] = e1.r0;
                nrec       = nrec + 3'd1;
            end
            if (e1.cnt == 2'd2) begin
                recs[nrec] = e1.r1;
                nrec       = nrec + 3'd1;
            end
            mode_next = M_IDLE;
            len_next  = 16'd0;
            cand_next = ALL_KW;
            do_idle   = 1'b1;
        end

        o1 = op1(char_code);
        if (do_idle) begin
            if (char_code == 8'h0A || is_space(char_code)) begin
                mode_next = M_IDLE;
            end
            else if (char_code == "#") begin
                mode_next = M_COMMENT;
            end
            else if (has_two(char_code)) begin
                mode_next  = M_OPQ;
                start_next = here;
                len_next   = 16'd0;
                la_next    = char_code;
            end
            else if (o1[6]) begin
                recs[nrec] = mkrec(o1[5:0], here, here.offset, 16'd1, ERR_NONE);
                nrec       = nrec + 3'd1;
            end
            else if (char_code == 8'h22 || char_code == 8'h27) begin
                mode_next  = (char_code == 8'h22) ? M_STRING : M_CHAR;
                start_next = here;
                len_next   = 16'd0;
            end
            else if (is_digit(char_code)) begin
                mode_next  = (char_code == "0") ? M_ZERO : M_DEC;
                start_next = here;
                len_next   = 16'd1;
            end
            else if (is_alpha(char_code) || char_code == "_") begin
                mode_next  = M_IDENT;
                start_next = here;
                len_next   = 16'd1;
                cand_next  = kw_upd(ALL_KW, char_code, 16'd0);
            end
            else begin
                recs[nrec] = mkrec(K_EOF, here, here.offset, 16'd1, ERR_BYTE);
                nrec       = nrec + 3'd1;
            end
        end

        if (char_code == 8'h0A) begin
            if (line_reg != 20'hFFFFF) line_next = line_reg + 20'd1;
            col_next = 16'd1;
        end
        else begin
            col_next = sat_inc16(col_reg);
        end
        pos_next = pos_reg + POS_ONE;

        eof_spot = '{line: line_next, column: col_next, offset: pos_next};
        e2       = end_recs(mode_next, start_next, pend_next, la_next, len_next, cand_next);
        if (end_of_source) begin
            if (e2.cnt != 2'd0) begin
                recs[nrec] = e2.r0;
                nrec       = nrec + 3'd1;
            end
            if (e2.cnt == 2'd2) begin
                recs[nrec] = e2.r1;
                nrec       = nrec + 3'd1;
            end
            recs[nrec] = mkrec(K_EOF, eof_spot, eof_spot.offset, 16'd0, ERR_NONE);
            nrec       = nrec + 3'd1;
            mode_next  = M_IDLE;
            la_next    = 8'h00;
            cand_next  = ALL_KW;
            len_next   = 16'd0;
            line_next  = 20'd1;
            col_next   = 16'd1;
            pos_next   = '0;
            start_next = '0;
            pend_next  = '0;
        end
    end

    assign push           = accept && (nrec != 3'd0);
    assign push_data.recs = recs;
    assign push_data.cnt  = nrec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            la_reg    <= 8'h00;
            cand_reg  <= ALL_KW;
            len_reg   <= 16'd0;
            line_reg  <= 20'd1;
            col_reg   <= 16'd1;
            pos_reg   <= '0;
            start_reg <= '0;
            pend_reg  <= '0;
        end
        else if (accept) begin
            mode_reg  <= mode_next;
            la_reg    <= la_next;
            cand_reg  <= cand_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

>>> rtl/stt_queue.sv
// Two-entry queue of token word groups between the front and back ends.
`timescale 1ns / 1ps

module stt_queue
    import stt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output bundle_t head,
    output logic    empty
);

    bundle_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/stt_back.sv
// Back end: sends each group's words via an output register, one per cycle if tok_ready.
`timescale 1ns / 1ps

module stt_back
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bundle_t     head,
    input  logic        empty,
    output logic        pop,
    output logic        tok_valid,
    input  logic        tok_ready,
    output logic [5:0]  token_kind,
    output logic [19:0] start_line,
    output logic [15:0] start_column,
    output logic [23:0] text_offset,
    output logic [15:0] text_length,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    rec_t       out_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;

    assign load    = !empty && (!valid_reg || tok_ready);
    assign is_last = (idx_reg == head.cnt - 3'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (tok_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg  <= head.recs[idx_reg];
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign tok_valid    = valid_reg;
    assign token_kind   = out_reg.kind;
    assign start_line   = out_reg.line;
    assign start_column = out_reg.column;
    assign text_offset  = out_reg.offset;
    assign text_length  = out_reg.length;
    assign error_code   = out_reg.err;
    assign last_of_run  = last_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> idx_reg < head.cnt)
        else $error("word index beyond group size");

    a_idx_reset: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 3'd0)
        else $error("word index not cleared after group");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> tok_valid)
        else $error("loaded word not presented");

endmodule

>>> rtl/source_text_tokenizer_unit.sv
// Top level of the source text tokenizer: front end, word group queue and back end.
//
//   Channel  Handshake               Payload
//   source   src_valid / src_ready   char_code, end_of_source
//   token    tok_valid / tok_ready   token_kind .. last_of_run
//
// One source byte is taken per cycle while the queue is not full; the front end updates
// the lexer state in that cycle. Each byte produces zero to four token words, sent one per
// cycle by the back end while tok_ready is high.
// Reset puts the lexer at line 1, column 1, offset 0 with no open token.
// A stalled token output backs up the two-entry queue, which then holds src_ready low.
`timescale 1ns / 1ps

module source_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int MAX_KEYWORD_LEN = 19,
    parameter int POSITION_BITS   = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  logic [7:0]  char_code,
    input  logic        end_of_source,
    output logic        tok_valid,
    input  logic        tok_ready,
    output logic [5:0]  token_kind,
    output logic [19:0] start_line,
    output logic [15:0] start_column,
    output logic [23:0] text_offset,
    output logic [15:0] text_length,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    logic    accept;
    logic    push;
    bundle_t push_data;
    logic    full;
    logic    pop;
    bundle_t head;
    logic    empty;

    assign src_ready = !full;
    assign accept    = src_valid && src_ready;

    stt_front #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
        .POSITION_BITS   (POSITION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .char_code     (char_code),
        .end_of_source (end_of_source),
        .push          (push),
        .push_data     (push_data)
    );

    stt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    stt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .tok_valid    (tok_valid),
        .tok_ready    (tok_ready),
        .token_kind   (token_kind),
        .start_line   (start_line),
        .start_column (start_column),
        .text_offset  (text_offset),
        .text_length  (text_length),
        .error_code   (error_code),
        .last_of_run  (last_of_run)
    );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the source text tokenizer: byte stream in, token records out.
`timescale 1ns / 1ps

module tb_top;
    import stt_pkg::*;

    typedef enum int {
        LX_IDLE, LX_OPQ, LX_COMMENT, LX_IDENT, LX_ZERO, LX_DEC, LX_DECDOT,
        LX_HEX, LX_BIN, LX_FRAC, LX_EXPE, LX_EXPD, LX_STRING, LX_CHAR
    } lex_mode_e;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] line;
        logic [15:0] column;
        logic [23:0] offset;
        logic [15:0] length;
        logic [1:0]  err;
        logic        last;
    } tok_rec_t;

    typedef struct {
        int unsigned line;
        int unsigned col;
        int unsigned off;
    } spot_t;

    localparam int KW_LIMIT  = 19;
    localparam int RUN_LIMIT = 300000;

    string op_names[36] = '{
        "==", "!=", "<=", ">=", "<<", ">>", "->", "+=", "-=", "*=", "/=", "%=",
        "++", "--", "+", "-", "*", "/", "=", "<", ">", "!", "&&", "||", "^", "~",
        "{", "}", "(", ")", ";", ",", "%", ":", "[", "]"
    };

    string kw_names[49] = '{
        "plus", "minus", "multiply", "divide", "equals", "equalsEquals", "notEquals",
        "lessThan", "lessThanOrEquals", "greaterThan", "greaterThanOrEquals", "and", "or",
        "xor", "complement", "leftShift", "rightShift", "pointer", "plusEquals",
        "minusEquals", "multiplyEquals", "divideEquals", "modEquals", "doing", "finish",
        "open", "close", "to", "end", "make", "list", "const", "true", "false", "function",
        "beginParams", "endParams", "if", "else", "while", "for", "return", "none", "NULL",
        "stop", "continue", "switch", "when", "default"
    };

    int kw_kinds[49] = '{
        14, 15, 16, 17, 18, 0, 1, 19, 2, 20, 3, 22, 23, 24, 25, 4, 5, 6, 7, 8, 9, 10, 11,
        26, 27, 28, 29, 36, 30, 37, 38, 39, 40, 41, 42, 28, 29, 43, 44, 45, 46, 47, 48, 49,
        50, 51, 52, 53, 54
    };

    class token_scoreboard;
        tok_rec_t    pending_tokens[$];
        tok_rec_t    step_tokens[$];
        lex_mode_e   mode;
        logic [7:0]  held_byte;
        logic [48:0] candidates;
        int unsigned line_no;
        int unsigned col_no;
        int unsigned byte_pos;
        int unsigned tok_len;
        spot_t       tok_start;
        spot_t       dot_spot;
        int          errors;

        function new();
            errors = 0;
            clear_source();
        endfunction

        function void go_idle();
            mode = LX_IDLE;
            tok_len = 0;
            candidates = '1;
        endfunction

        function void clear_source();
            go_idle();
            held_byte = 8'h00;
            line_no = 1;
            col_no = 1;
            byte_pos = 0;
            tok_start = '{0, 0, 0};
            dot_spot = tok_start;
        endfunction

        function void emit(int kind, spot_t s, int unsigned off, int unsigned len, int err);
            tok_rec_t r;
            if (step_tokens.size() >= MAX_RESULTS) return;
            r.kind = kind[5:0];
            r.line = s.line[19:0];
            r.column = s.col[15:0];
            r.offset = off[23:0];
            r.length = len[15:0];
            r.err = err[1:0];
            r.last = 1'b0;
            step_tokens.push_back(r);
        endfunction

        function int find_op(logic [7:0] c0, logic [7:0] c1, bit have_second);
            for (int k = 0; k < 36; k++) begin
                if (op_names[k].len() == 1) begin
                    if (op_names[k][0] == c0) return k;
                end else if (have_second && op_names[k][0] == c0 && op_names[k][1] == c1) begin
                    return k;
                end
            end
            return -1;
        endfunction

        function bit starts_pair(logic [7:0] c);
            if (c == "/") return 1;
            for (int k = 0; k < 36; k++)
                if (op_names[k].len() == 2 && op_names[k][0] == c) return 1;
            return 0;
        endfunction

        function logic [7:0] kw_ch(int k, int unsigned i);
            if (i < kw_names[k].len()) return kw_names[k][i];
            return 8'h00;
        endfunction

        function void grow();
            if (tok_len < 65535) tok_len++;
        endfunction

        function void narrow_keywords(logic [7:0] c);
            if (tok_len >= KW_LIMIT) begin
                candidates = '0;
                return;
            end
            for (int k = 0; k < 49; k++)
                if (kw_ch(k, tok_len) != c) candidates[k] = 1'b0;
        endfunction

        function int ident_kind();
            if (tok_len > KW_LIMIT) return K_IDENT;
            for (int k = 0; k < 49; k++)
                if (candidates[k] && kw_ch(k, tok_len) == 8'h00) return kw_kinds[k];
            return K_IDENT;
        endfunction

        function void close_token();
            spot_t s;
            int k;
            s = tok_start;
            case (mode)
                LX_OPQ: begin
                    k = find_op(held_byte, 8'h00, 0);
                    if (k >= 0) emit(k, s, s.off, 1, ERR_NONE);
                    else emit(K_EOF, s, s.off, 1, ERR_BYTE);
                end
                LX_IDENT: emit(ident_kind(), s, s.off, tok_len, ERR_NONE);
                LX_ZERO, LX_DEC: emit(K_NUMBER, s, s.off, tok_len, ERR_NONE);
                LX_DECDOT: begin
                    emit(K_NUMBER, s, s.off, tok_len, ERR_NONE);
                    emit(K_EOF, dot_spot, dot_spot.off, 1, ERR_BYTE);
                end
                LX_HEX: emit(K_HEX, s, s.off, tok_len, ERR_NONE);
                LX_BIN: emit(K_BINARY, s, s.off, tok_len, ERR_NONE);
                LX_FRAC, LX_EXPE, LX_EXPD: emit(K_FLOAT, s, s.off, tok_len, ERR_NONE);
                LX_STRING: emit(K_STRING, s, (s.off + 1) & 24'hFFFFFF, tok_len, ERR_STRING);
                LX_CHAR: emit(K_CHAR, s, (s.off + 1) & 24'hFFFFFF, 0, ERR_CHAR);
                default: ;
            endcase
            go_idle();
        endfunction

        function void open_token(lex_mode_e m, spot_t p);
            mode = m;
            tok_start = p;
            tok_len = 0;
        endfunction

        function void lex_idle(logic [7:0] c, spot_t p);
            int k;
            if (c == 8'h0A || c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D)
                return;
            if (c == "#") begin
                mode = LX_COMMENT;
                return;
            end
            if (starts_pair(c)) begin
                open_token(LX_OPQ, p);
                held_byte = c;
                return;
            end
            k = find_op(c, 8'h00, 0);
            if (k >= 0) begin
                emit(k, p, p.off, 1, ERR_NONE);
                return;
            end
            if (c == "\"") begin
                open_token(LX_STRING, p);
                return;
            end
            if (c == "'") begin
                open_token(LX_CHAR, p);
                return;
            end
            if (c >= "0" && c <= "9") begin
                open_token(c == "0" ? LX_ZERO : LX_DEC, p);
                grow();
                return;
            end
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
                open_token(LX_IDENT, p);
                candidates = '1;
                narrow_keywords(c);
                grow();
                return;
            end
            emit(K_EOF, p, p.off, 1, ERR_BYTE);
        endfunction

        function void lex_byte(logic [7:0] c, spot_t p);
            bit again;
            bit dig;
            int k;
            dig = c >= "0" && c <= "9";
            do begin
                again = 0;
                case (mode)
                    LX_IDLE: lex_idle(c, p);
                    LX_COMMENT: if (c == 8'h0A) begin
                        mode = LX_IDLE;
                        again = 1;
                    end
                    LX_OPQ: begin
                        k = find_op(held_byte, c, 1);
                        if (held_byte == "/" && c == "/") begin
                            go_idle();
                            mode = LX_COMMENT;
                        end else if (k >= 0 && op_names[k].len() == 2) begin
                            emit(k, tok_start, tok_start.off, 2, ERR_NONE);
                            go_idle();
                        end else begin
                            close_token();
                            again = 1;
                        end
                    end
                    LX_IDENT: begin
                        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || dig
                            || c == "_") begin
                            narrow_keywords(c);
                            grow();
                        end else begin
                            close_token();
                            again = 1;
                        end
                    end
                    LX_ZERO: begin
                        if (c == "x" || c == "X") begin
                            mode = LX_HEX;
                            grow();
                        end else if (c == "b" || c == "B") begin
                            mode = LX_BIN;
                            grow();
                        end else begin
                            mode = LX_DEC;
                            again = 1;
                        end
                    end
                    LX_DEC: begin
                        if (dig) grow();
                        else if (c == ".") begin
                            mode = LX_DECDOT;
                            held_byte = c;
                            dot_spot = p;
                        end else begin
                            close_token();
                            again = 1;
                        end
                    end
                    LX_DECDOT: begin
                        if (dig) begin
                            mode = LX_FRAC;
                            grow();
                            grow();
                        end else begin
                            close_token();
                            again = 1;
                        end
                    end
                    LX_HEX: begin
                        if (dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")) grow();
                        else begin
                            close_token();
                            again = 1;
                        end
                    end
                    LX_BIN: begin
                        if (c == "0" || c == "1") grow();
                        else begin
                            close_token();
                            again = 1;
                        end
                    end
                    LX_FRAC: begin
                        if (dig) grow();
                        else if (c == "e" || c == "E") begin
                            mode = LX_EXPE;
                            grow();
                        end else begin
                            close_token();
                            again = 1;
                        end
                    end
                    LX_EXPE: begin
                        if (c == "+" || c == "-" || dig) begin
                            mode = LX_EXPD;
                            grow();
                        end else begin
                            close_token();
                            again = 1;
                        end
                    end
                    LX_EXPD: begin
                        if (dig) grow();
                        else begin
                            close_token();
                            again = 1;
                        end
                    end
                    LX_STRING: begin
                        if (c == "\"") begin
                            emit(K_STRING, tok_start, (tok_start.off + 1) & 24'hFFFFFF,
                                 tok_len, ERR_NONE);
                            go_idle();
                        end else begin
                            grow();
                        end
                    end
                    LX_CHAR: begin
                        if (c == "'" || c == 8'h0A) begin
                            emit(K_CHAR, tok_start, (tok_start.off + 1) & 24'hFFFFFF,
                                 tok_len, c == 8'h0A ? ERR_CHAR : ERR_NONE);
                            go_idle();
                            again = c == 8'h0A;
                        end else begin
                            grow();
                        end
                    end
                    default: begin
                        go_idle();
                        again = 1;
                    end
                endcase
            end while (again);
        endfunction

        function void note_input(logic [7:0] c, logic eos);
            spot_t p;
            step_tokens.delete();
            p = '{line_no, col_no, byte_pos};
            lex_byte(c, p);
            if (c == 8'h0A) begin
                if (line_no < 20'hFFFFF) line_no++;
                col_no = 1;
            end else if (col_no < 65535) begin
                col_no++;
            end
            byte_pos = (byte_pos + 1) & 24'hFFFFFF;
            if (eos) begin
                close_token();
                p = '{line_no, col_no, byte_pos};
                emit(K_EOF, p, p.off, 0, ERR_NONE);
                clear_source();
            end
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
        endfunction

        function void check_result(tok_rec_t got);
            tok_rec_t want;
            if (pending_tokens.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected token word: kind %0d", got.kind);
                return;
            end
            want = pending_tokens.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"Token mismatch: expected kind %0d line %0d col %0d off %0d ",
                              "len %0d err %0d last %0d, got %0d %0d %0d %0d %0d %0d %0d"},
                             want.kind, want.line, want.column, want.offset, want.length,
                             want.err, want.last, got.kind, got.line, got.column, got.offset,
                             got.length, got.err, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_ready;
    logic [7:0]  char_code;
    logic        end_of_source;
    logic        tok_valid;
    logic        tok_ready;
    logic [5:0]  token_kind;
    logic [19:0] start_line;
    logic [15:0] start_column;
    logic [23:0] text_offset;
    logic [15:0] text_length;
    logic [1:0]  error_code;
    logic        last_of_run;

    token_scoreboard sb = new();
    bit              quiet_phase;
    int              cycle_count;
    int              bytes_sent;
    logic [7:0]      src_bytes[$];

    source_text_tokenizer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_ready     (src_ready),
        .char_code     (char_code),
        .end_of_source (end_of_source),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .token_kind    (token_kind),
        .start_line    (start_line),
        .start_column  (start_column),
        .text_offset   (text_offset),
        .text_length   (text_length),
        .error_code    (error_code),
        .last_of_run   (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (src_valid && src_ready) sb.note_input(char_code, end_of_source);
            if (tok_valid && tok_ready)
                sb.check_result({token_kind, start_line, start_column, text_offset,
                                 text_length, error_code, last_of_run});
        end
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        tok_ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (!quiet_phase && $urandom_range(0, 2) == 0) begin
                tok_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            tok_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic eos);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        src_valid <= 1'b1;
        char_code <= c;
        end_of_source <= eos;
        do @(posedge clk); while (!src_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_source();
        foreach (src_bytes[i]) send_byte(src_bytes[i], i == src_bytes.size() - 1);
        src_bytes.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] word_char(input bit first);
        case ($urandom_range(0, first ? 2 : 3))
            0: return 8'($urandom_range("a", "z"));
            1: return 8'($urandom_range("A", "Z"));
            2: return "_";
            default: return 8'($urandom_range("0", "9"));
        endcase
    endfunction

    task automatic add_digits(input logic [7:0] lo, input logic [7:0] hi, input int n);
        repeat (n) src_bytes.push_back(8'($urandom_range(lo, hi)));
    endtask

    task automatic add_fragment();
        int n;
        case ($urandom_range(0, 17))
            0, 1: add_text(kw_names[$urandom_range(0, 48)]);
            2: begin
                add_text(kw_names[$urandom_range(0, 48)]);
                src_bytes.push_back(word_char(0));
            end
            3, 4: begin
                n = $urandom_range(0, 3) == 0 ? $urandom_range(15, 24) : $urandom_range(1, 6);
                src_bytes.push_back(word_char(1));
                repeat (n - 1) src_bytes.push_back(word_char(0));
            end
            5: begin
                add_digits("0", "9", $urandom_range(1, 5));
                if ($urandom_range(0, 1)) begin
                    src_bytes.push_back(".");
                    add_digits("0", "9", $urandom_range(0, 3));
                end
            end
            6: begin
                add_text($urandom_range(0, 1) ? "0x" : "0X");
                repeat ($urandom_range(0, 5))
                    src_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range("a", "f"))
                                                             : 8'($urandom_range("0", "9")));
            end
            7: begin
                add_text($urandom_range(0, 1) ? "0b" : "0B");
                add_digits("0", "2", $urandom_range(0, 6));
            end
            8: begin
                add_digits("0", "9", $urandom_range(1, 3));
                src_bytes.push_back(".");
                add_digits("0", "9", $urandom_range(1, 3));
                if ($urandom_range(0, 1)) begin
                    src_bytes.push_back($urandom_range(0, 1) ? "e" : "E");
                    case ($urandom_range(0, 2))
                        0: src_bytes.push_back("+");
                        1: src_bytes.push_back("-");
                        default: ;
                    endcase
                    add_digits("0", "9", $urandom_range(0, 3));
                end
            end
            9: begin
                src_bytes.push_back("\"");
                repeat ($urandom_range(0, 8)) begin
                    n = $urandom_range(0, 9) == 0 ? 10 : $urandom_range(32, 126);
                    src_bytes.push_back(n == 34 ? 8'h20 : 8'(n));
                end
                if ($urandom_range(0, 7) != 0) src_bytes.push_back("\"");
            end
            10: begin
                src_bytes.push_back("'");
                repeat ($urandom_range(0, 2)) src_bytes.push_back(8'($urandom_range(97, 122)));
                case ($urandom_range(0, 5))
                    0: src_bytes.push_back(8'h0A);
                    1: ;
                    default: src_bytes.push_back("'");
                endcase
            end
            11, 12, 13: add_text(op_names[$urandom_range(0, 35)]);
            14: add_text($urandom_range(0, 1) ? "&" : "|");
            15: begin
                add_text($urandom_range(0, 1) ? "#" : "//");
                repeat ($urandom_range(0, 6)) src_bytes.push_back(8'($urandom_range(32, 126)));
                src_bytes.push_back(8'h0A);
            end
            16: src_bytes.push_back(8'($urandom_range(0, 255)));
            default: begin
                case ($urandom_range(0, 5))
                    0: src_bytes.push_back(8'h09);
                    1: src_bytes.push_back(8'h0B);
                    2: src_bytes.push_back(8'h0C);
                    3: src_bytes.push_back(8'h0D);
                    4: src_bytes.push_back(8'h0A);
                    default: src_bytes.push_back(" ");
                endcase
            end
        endcase
        case ($urandom_range(0, 3))
            0: ;
            1: src_bytes.push_back(8'h0A);
            default: src_bytes.push_back(" ");
        endcase
    endtask

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        src_valid = 1'b0;
        char_code = 8'h00;
        end_of_source = 1'b0;
        quiet_phase = 1'b0;
        bytes_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_text("if x>=0b12.5e+3 1.a 'c\n#q\n");
        src_bytes.push_back(8'h00);
        src_bytes.push_back(8'hFF);
        add_text("&\"a");
        send_source();
        add_text("7.");
        send_source();

        while (bytes_sent < 430) begin
            if (bytes_sent > 370) quiet_phase = 1'b1;
            repeat ($urandom_range(1, 8)) add_fragment();
            send_source();
        end
        src_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending_tokens.size() != 0 && wait_cycles < 5000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_tokens.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
